FILE: hdl/tam_pkg.sv
// Shared types and constants of the tiny accumulator machine.
// Holds the beat payloads, opcode and result-kind codes, FSM states and the divider bundle.
// No dependencies.
package tam_pkg;

   typedef enum logic [3:0] {
      OP_LOAD  = 4'd0,
      OP_WRITE = 4'd1,
      OP_PRINT = 4'd2,
      OP_MOVE  = 4'd3,
      OP_ADD   = 4'd4,
      OP_SUB   = 4'd5,
      OP_MUL   = 4'd6,
      OP_DIV   = 4'd7,
      OP_MOD   = 4'd8,
      OP_CMP   = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      KIND_VALUE = 2'd0,
      KIND_UNDEF = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_B,
      ST_EXEC,
      ST_DIV,
      ST_COMMIT,
      ST_MOVE,
      ST_EMIT_VAL,
      ST_EMIT_ERR,
      ST_PRINT
   } state_type;

   typedef struct packed {
      logic [3:0]        opcode;
      logic              first_is_memory;
      logic [3:0]        first_index;
      logic              second_is_memory;
      logic [3:0]        second_index;
      logic signed [7:0] immediate;
   } req_type;

   typedef struct packed {
      logic [1:0]        result_kind;
      logic signed [7:0] value;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic signed [8:0] dividend;
      logic signed [8:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic signed [8:0] quo;
      logic signed [8:0] rem;
   } div_res_type;

   // Stored values are 9-bit signed; +128 marks an undefined entry.
   localparam logic signed [8:0] UNDEF_VAL  = 9'sd128;
   localparam logic signed [8:0] VAL_MAX9   = 9'sd127;
   localparam logic signed [7:0] IMM_REJECT = 8'sh80;

   localparam int ZF_BIT = 0;
   localparam int SF_BIT = 1;
   localparam int OF_BIT = 2;

   // Restoring divider over 8-bit magnitudes.
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Build one result beat from a stored value: +128 reports as undefined.
   function automatic rsp_type emit_val(input logic signed [8:0] v, input logic is_last);
      rsp_type r;
      r.last = is_last;
      if (v > VAL_MAX9) begin
         r.result_kind = KIND_UNDEF;
         r.value       = '0;
      end else begin
         r.result_kind = KIND_VALUE;
         r.value       = v[7:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/tam_div.sv
// Iterative signed divider for the tiny accumulator machine: one quotient bit per cycle.
// Truncating quotient and C remainder of 9-bit operands; divisor must be nonzero.
// Depends on tam_pkg.
module tam_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tam_pkg::div_req_type div_req,
   output logic                 done,
   output tam_pkg::div_res_type div_res
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [tam_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [tam_pkg::DIV_CNT_W-1:0]  cnt_in;
   logic [7:0]                     rem_ff;
   logic [7:0]                     rem_in;
   logic [7:0]                     quo_ff;
   logic [7:0]                     quo_in;
   logic [7:0]                     ub_ff;
   logic                           neg_q_ff;
   logic                           neg_r_ff;
   logic [8:0]                     abs_a;
   logic [8:0]                     abs_b;
   logic [8:0]                     trial;
   logic [9:0]                     diff;
   logic                           ge;
   logic [8:0]                     qmag;
   logic [8:0]                     rmag;

   assign abs_a = div_req.dividend[8] ? 9'(-div_req.dividend) : div_req.dividend;
   assign abs_b = div_req.divisor[8]  ? 9'(-div_req.divisor)  : div_req.divisor;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign trial  = {rem_ff, quo_ff[7]};
   assign diff   = {1'b0, trial} - {2'b00, ub_ff};
   assign ge     = ~diff[9];
   assign rem_in = ge ? diff[7:0] : trial[7:0];
   assign quo_in = {quo_ff[6:0], ge};
   assign cnt_in = cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_in;
            if (cnt_ff == tam_pkg::DIV_CNT_W'(tam_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff   <= abs_a[7:0];
         rem_ff   <= '0;
         ub_ff    <= abs_b[7:0];
         neg_q_ff <= div_req.dividend[8] ^ div_req.divisor[8];
         neg_r_ff <= div_req.dividend[8];
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Apply signs: quotient by sign product, remainder follows the dividend.
   assign qmag        = {1'b0, quo_ff};
   assign rmag        = {1'b0, rem_ff};
   assign div_res.quo = neg_q_ff ? $signed(9'(-qmag)) : $signed(qmag);
   assign div_res.rem = neg_r_ff ? $signed(9'(-rmag)) : $signed(rmag);
   assign done        = done_ff;

endmodule

FILE: hdl/tiny_accumulator_machine_core.sv
// Top level of the tiny accumulator machine: decoder/sequencer, unified storage RAM, output stage.
// Registers and memory words share one synchronous RAM; divide and modulo use tam_div.
// Depends on tam_pkg and tam_div.
//
//   channel | direction | handshake            | beat payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_stall  | tam_pkg::req_type (one instruction)
//   rsp     | out       | rsp_valid/rsp_stall  | tam_pkg::rsp_type (one result)
//
// Load writes the RAM when accepted; move reads, then writes; compare reads both and sets ZF/SF;
// add/sub/mul read both, execute, commit; div/mod run the bit-serial divider before commit; write
// reads, then waits for output; print streams entries then flags, a registered RAM read per entry.
// One instruction is in flight at a time; req_stall is high until its last RAM write, flag update
// or last result is handed to the output register, which holds one beat while rsp_stall is high.
// Reset is synchronous: flags clear and per-entry valid bits make every word read as +128.
module tiny_accumulator_machine_core #(
   parameter int REG_COUNT = 4,
   parameter int MEM_WORDS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tam_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tam_pkg::rsp_type rsp_data
);

   localparam int N_ENT     = REG_COUNT + MEM_WORDS;
   localparam int ADDR_W    = $clog2(N_ENT);
   localparam int PRINT_LEN = N_ENT + 3;
   localparam int CNT_W     = $clog2(PRINT_LEN);

   localparam logic [4:0]        REG_LIM      = 5'(REG_COUNT);
   localparam logic [4:0]        MEM_LIM      = 5'(MEM_WORDS);
   localparam logic [ADDR_W-1:0] MEM_BASE     = ADDR_W'(REG_COUNT);
   localparam logic [CNT_W-1:0]  CNT_ENT_LAST = CNT_W'(N_ENT - 1);
   localparam logic [CNT_W-1:0]  CNT_ZF       = CNT_W'(N_ENT);
   localparam logic [CNT_W-1:0]  CNT_SF       = CNT_W'(N_ENT + 1);
   localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(PRINT_LEN - 1);

   // Sequencer state
   tam_pkg::state_type      state_ff, state_in;
   logic [3:0]              op_ff, op_in;
   logic [ADDR_W-1:0]       addr_b_ff, addr_b_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [8:0]       a_ff, a_in;
   logic signed [17:0]      res_ff, res_in;
   logic                    ovf_ff, ovf_in;
   logic [2:0]              flag_ff, flag_in;

   // Output stage
   logic                    rsp_valid_ff, rsp_valid_in;
   tam_pkg::rsp_type        rsp_data_ff, rsp_data_in;
   logic                    out_free;
   logic                    out_load;
   tam_pkg::rsp_type        out_data;

   // Storage RAM: registers first, then memory words
   logic signed [8:0]       store_ff [N_ENT];
   logic [N_ENT-1:0]        vld_ff;
   logic signed [8:0]       rd_data_ff;
   logic                    rd_vld_ff;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [8:0]       wr_data;
   logic signed [8:0]       rd_val;

   // Decode of the incoming beat
   logic                    accept;
   logic                    ok1, ok2, reg1_ok, reg2_ok;
   logic                    pair_bad, cmp_bad;
   logic [ADDR_W-1:0]       addr1, addr2;
   logic                    commit_ovf;

   // Divider
   tam_pkg::div_req_type    div_req;
   tam_pkg::div_res_type    div_res;
   logic                    div_done;
   logic                    div_start;

   function automatic logic [ADDR_W-1:0] addr_of(input logic is_mem, input logic [3:0] idx);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(idx);
      if (is_mem) begin
         a = MEM_BASE + a;
      end
      return a;
   endfunction

   tam_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .done    (div_done),
      .div_res (div_res)
   );

   assign div_req.start    = div_start;
   assign div_req.dividend = a_ff;
   assign div_req.divisor  = rd_val;

   // Unwritten entries read as undefined.
   assign rd_val = rd_vld_ff ? rd_data_ff : tam_pkg::UNDEF_VAL;

   assign req_stall = (state_ff != tam_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // Index range checks per operand location
   assign reg1_ok  = ({1'b0, req_data.first_index}  < REG_LIM);
   assign reg2_ok  = ({1'b0, req_data.second_index} < REG_LIM);
   assign ok1      = req_data.first_is_memory  ?
                     ({1'b0, req_data.first_index}  < MEM_LIM) : reg1_ok;
   assign ok2      = req_data.second_is_memory ?
                     ({1'b0, req_data.second_index} < MEM_LIM) : reg2_ok;
   assign pair_bad = (req_data.first_is_memory & req_data.second_is_memory) | ~ok1 | ~ok2;
   assign cmp_bad  = req_data.first_is_memory | req_data.second_is_memory |
                     ~reg1_ok | ~reg2_ok;
   assign addr1    = addr_of(req_data.first_is_memory,  req_data.first_index);
   assign addr2    = addr_of(req_data.second_is_memory, req_data.second_index);

   assign commit_ovf = ovf_ff | (res_ff > 18'sd127) | (res_ff < -18'sd128);

   // Output register frees up when empty or when its beat is taken this cycle.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      addr_b_in = addr_b_ff;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      res_in    = res_ff;
      ovf_in    = ovf_ff;
      flag_in   = flag_ff;
      rd_en     = 1'b0;
      rd_addr   = addr1;
      wr_en     = 1'b0;
      wr_addr   = addr1;
      wr_data   = {req_data.immediate[7], req_data.immediate};
      out_load  = 1'b0;
      out_data  = tam_pkg::emit_val(rd_val, 1'b1);
      div_start = 1'b0;

      unique case (state_ff)
         tam_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.opcode;
               addr_b_in = addr2;
               unique case (req_data.opcode) inside
                  tam_pkg::OP_LOAD: begin
                     if (!ok1 || req_data.immediate == tam_pkg::IMM_REJECT) begin
                        state_in = tam_pkg::ST_EMIT_ERR;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  tam_pkg::OP_WRITE: begin
                     if (!ok1) begin
                        state_in = tam_pkg::ST_EMIT_ERR;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = tam_pkg::ST_EMIT_VAL;
                     end
                  end
                  tam_pkg::OP_PRINT: begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     cnt_in   = '0;
                     state_in = tam_pkg::ST_PRINT;
                  end
                  tam_pkg::OP_MOVE: begin
                     if (pair_bad) begin
                        state_in = tam_pkg::ST_EMIT_ERR;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = tam_pkg::ST_MOVE;
                     end
                  end
                  tam_pkg::OP_ADD, tam_pkg::OP_SUB, tam_pkg::OP_MUL,
                  tam_pkg::OP_DIV, tam_pkg::OP_MOD: begin
                     if (pair_bad) begin
                        state_in = tam_pkg::ST_EMIT_ERR;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = tam_pkg::ST_READ_B;
                     end
                  end
                  tam_pkg::OP_CMP: begin
                     if (cmp_bad) begin
                        state_in = tam_pkg::ST_EMIT_ERR;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = tam_pkg::ST_READ_B;
                     end
                  end
                  default: begin
                     state_in = tam_pkg::ST_EMIT_ERR;
                  end
               endcase
            end
         end

         tam_pkg::ST_READ_B: begin
            // Hold the first operand, fetch the second.
            a_in     = rd_val;
            rd_en    = 1'b1;
            rd_addr  = addr_b_ff;
            state_in = tam_pkg::ST_EXEC;
         end

         tam_pkg::ST_EXEC: begin
            ovf_in   = 1'b0;
            state_in = tam_pkg::ST_COMMIT;
            case (op_ff) inside
               tam_pkg::OP_ADD: res_in = 18'(a_ff) + 18'(rd_val);
               tam_pkg::OP_SUB: res_in = 18'(rd_val) - 18'(a_ff);
               tam_pkg::OP_MUL: res_in = 18'(a_ff) * 18'(rd_val);
               tam_pkg::OP_DIV, tam_pkg::OP_MOD: begin
                  if (rd_val == '0) begin
                     // A zero divisor counts as overflow.
                     ovf_in = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = tam_pkg::ST_DIV;
                  end
               end
               default: begin
                  // Compare: OF stays, ZF and SF from the ordering.
                  flag_in[tam_pkg::ZF_BIT] = (a_ff == rd_val);
                  flag_in[tam_pkg::SF_BIT] = (a_ff > rd_val);
                  state_in                 = tam_pkg::ST_IDLE;
               end
            endcase
         end

         tam_pkg::ST_DIV: begin
            if (div_done) begin
               res_in   = (op_ff == tam_pkg::OP_DIV) ? 18'($signed(div_res.quo)) :
                                                       18'($signed(div_res.rem));
               state_in = tam_pkg::ST_COMMIT;
            end
         end

         tam_pkg::ST_COMMIT: begin
            wr_en                    = 1'b1;
            wr_addr                  = '0;
            wr_data                  = commit_ovf ? tam_pkg::UNDEF_VAL : res_ff[8:0];
            flag_in[tam_pkg::OF_BIT] = commit_ovf;
            state_in                 = tam_pkg::ST_IDLE;
         end

         tam_pkg::ST_MOVE: begin
            wr_en    = 1'b1;
            wr_addr  = addr_b_ff;
            wr_data  = rd_val;
            state_in = tam_pkg::ST_IDLE;
         end

         tam_pkg::ST_EMIT_VAL: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = tam_pkg::ST_IDLE;
            end
         end

         tam_pkg::ST_EMIT_ERR: begin
            out_data.result_kind = tam_pkg::KIND_ERROR;
            out_data.value       = '0;
            out_data.last        = 1'b1;
            if (out_free) begin
               out_load = 1'b1;
               state_in = tam_pkg::ST_IDLE;
            end
         end

         tam_pkg::ST_PRINT: begin
            // Stream entries, then ZF, SF, OF; every entry beat but the last prefetches the next.
            if (cnt_ff > CNT_ENT_LAST) begin
               out_data.result_kind = tam_pkg::KIND_VALUE;
               if (cnt_ff == CNT_ZF) begin
                  out_data.value = {7'b0, flag_ff[tam_pkg::ZF_BIT]};
               end else if (cnt_ff == CNT_SF) begin
                  out_data.value = {7'b0, flag_ff[tam_pkg::SF_BIT]};
               end else begin
                  out_data.value = {7'b0, flag_ff[tam_pkg::OF_BIT]};
               end
            end
            out_data.last = (cnt_ff == CNT_LAST);
            if (out_free) begin
               out_load = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               if (cnt_ff < CNT_ENT_LAST) begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_in[ADDR_W-1:0];
               end
               if (cnt_ff == CNT_LAST) begin
                  state_in = tam_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = tam_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   assign rsp_data_in  = out_load ? out_data : rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tam_pkg::ST_IDLE;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_b_ff   <= addr_b_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
      res_ff      <= res_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Storage RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result beat loaded over a beat still waiting");

   a_ram_port: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("RAM read and write issued in the same cycle");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (rd_val != '0) && (state_ff == tam_pkg::ST_EXEC))
      else $error("divider started with a zero divisor or outside execute");

   a_of_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tam_pkg::ST_COMMIT) |=> (flag_ff[tam_pkg::OF_BIT] == $past(commit_ovf)))
      else $error("OF does not match the committed overflow");

endmodule
